// ===== sv/lfrspi_pkg.sv =====
// Shared types and constants for the wake-up receiver serial frame master.
// Used by lfrspi_cfg, lfrspi_seq and lf_receiver_spi_frame_master_unit.
package lfrspi_pkg;

  // sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  // request kinds
  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // frame kinds
  localparam logic [1:0] KindCmd   = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  // frame prefixes in the upper byte of the shift register
  localparam logic [7:0] PrefixCmd  = 8'hC0;
  localparam logic [7:0] PrefixRead = 8'h40;

  // bit counts of the phases
  localparam logic [4:0] BitsShort = 5'd8;
  localparam logic [4:0] BitsLong  = 5'd16;

  // configuration register
  localparam int unsigned  ApbAddrW    = 3;
  localparam logic         RegGapTicks = 1'b0;
  localparam logic [15:0]  GapReset    = 16'd20;

  // stream payload widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;

  // one input request
  typedef struct packed {
    logic       req_type;
    logic [1:0] frame_kind;
    logic [5:0] command_code;
    logic [5:0] reg_addr;
    logic [7:0] wr_data;
    logic       miso;
  } item_t;

  // one result
  typedef struct packed {
    logic       cs_level;
    logic       sck_level;
    logic       mosi_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

// ===== sv/lf_receiver_spi_frame_master_unit.sv =====
// Top level of the wake-up receiver serial frame master: input stage,
// sequencer, result register and configuration port. Depends on lfrspi_pkg,
// lfrspi_cfg and lfrspi_seq.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+-------------------------------
//   s_axis    | in        | s_axis_tvalid/tready   | tdata: code, addr, data, miso
//             |           |                        | tuser: req_type, frame_kind
//   m_axis    | out       | m_axis_tvalid/tready   | tdata: pins, busy, done, rx, rej
//   apb       | in        | psel/penable, pready=1 | gap_ticks at byte address 0
//
// One request per cycle while m_axis is not stalled: each request is held in
// the input register, the sequencer step is short combinational logic, and
// the result is registered in the result register, which drives m_axis.
// Throughput is one request a cycle while m_axis is not stalled, set by the
// single state update of the sequencer. A stall on m_axis holds the result
// and the input register; s_axis_tready drops only once both are full.
// Reset clears the sequencer to idle with all pins low and sets the gap to
// 20 ticks.
module lf_receiver_spi_frame_master_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] command_code, [11:6] reg_addr, [19:12] wr_data, [20] miso, [23:21] zero
  input  logic [lfrspi_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] req_type, [2:1] frame_kind
  input  logic [lfrspi_pkg::InUserW-1:0]    s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] cs_level, [1] sck_level, [2] mosi_level, [3] busy_res, [4] done_res,
  // [12:5] read_data, [13] rejected, [15:14] zero
  output logic [lfrspi_pkg::OutDataW-1:0]   m_axis_tdata,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfrspi_pkg::ApbAddrW-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic              in_vld_q;
  lfrspi_pkg::item_t in_q;
  logic              out_vld_q;
  lfrspi_pkg::res_t  out_q;
  lfrspi_pkg::res_t  step_res;
  logic              advance;
  logic              in_take;
  logic [15:0]       gap_ticks;

  // pipeline control
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type     <= s_axis_tuser[0];
      in_q.frame_kind   <= s_axis_tuser[2:1];
      in_q.command_code <= s_axis_tdata[5:0];
      in_q.reg_addr     <= s_axis_tdata[11:6];
      in_q.wr_data      <= s_axis_tdata[19:12];
      in_q.miso         <= s_axis_tdata[20];
    end
  end

  // configuration registers
  lfrspi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gap_ticks_o (gap_ticks)
  );

  // sequencer
  lfrspi_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .gap_ticks_i (gap_ticks),
    .res_o       (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (~out_vld_q | m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  // result packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.rejected, out_q.read_data, out_q.done_res,
                          out_q.busy_res, out_q.mosi_level, out_q.sck_level,
                          out_q.cs_level};

  // a finished transaction is never reported as still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.done_res && out_q.busy_res))
    else $error("done reported while busy");

  // a rejected start only happens during a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.rejected) |-> (out_q.busy_res && out_q.cs_level))
    else $error("start rejected while idle");

  // sck and mosi only move while chip select is high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.cs_level) |-> (!out_q.sck_level && !out_q.mosi_level))
    else $error("serial pins active without chip select");

  // every request stepped through the sequencer lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result lost after sequencer step");

endmodule

// ===== sv/lfrspi_cfg.sv =====
// APB-style register file holding the gap length after the last bit.
// Depends on lfrspi_pkg.
module lfrspi_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfrspi_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [15:0]                   gap_ticks_o
);

  logic [15:0] gap_ticks_q;
  logic        wr_en;
  logic        sel_gap;

  // register decode, word index in the top address bit
  assign sel_gap = (paddr[lfrspi_pkg::ApbAddrW-1] == lfrspi_pkg::RegGapTicks);
  assign wr_en   = psel & penable & pwrite & sel_gap;
  assign pready  = 1'b1;

  // gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= lfrspi_pkg::GapReset;
    end else if (wr_en) begin
      gap_ticks_q <= pwdata[15:0];
    end
  end

  // read back
  assign prdata      = sel_gap ? {16'd0, gap_ticks_q} : 32'd0;
  assign gap_ticks_o = gap_ticks_q;

endmodule

// ===== sv/lfrspi_seq.sv =====
// Frame sequencer: phase, shift registers, counters and pin levels.
// Computes the result of one request and commits the state on step_i. Depends on lfrspi_pkg.
module lfrspi_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  lfrspi_pkg::item_t  item_i,
  input  logic [15:0]        gap_ticks_i,
  output lfrspi_pkg::res_t   res_o
);

  lfrspi_pkg::phase_e phase_q, phase_d;
  logic [15:0] tx_q, tx_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        half_q, half_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  rx_q, rx_d;
  logic [15:0] gap_q, gap_d;
  logic        cs_q, cs_d;
  logic        sck_q, sck_d;
  logic        mosi_q, mosi_d;
  logic        done, rej;
  logic [4:0]  cnt_inc;
  logic [4:0]  nbits;

  assign cnt_inc = cnt_q + 5'd1;
  assign nbits   = (kind_q == lfrspi_pkg::KindWrite) ? lfrspi_pkg::BitsLong
                                                     : lfrspi_pkg::BitsShort;

  // next state for one request
  always_comb begin
    phase_d = phase_q;
    tx_d    = tx_q;
    cnt_d   = cnt_q;
    half_d  = half_q;
    kind_d  = kind_q;
    rx_d    = rx_q;
    gap_d   = gap_q;
    cs_d    = cs_q;
    sck_d   = sck_q;
    mosi_d  = mosi_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (item_i.req_type == lfrspi_pkg::ReqStart) begin
      if (phase_q != lfrspi_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        kind_d = item_i.frame_kind;
        case (item_i.frame_kind)
          lfrspi_pkg::KindCmd:   tx_d = {lfrspi_pkg::PrefixCmd | {2'b00, item_i.command_code},
                                         8'd0};
          lfrspi_pkg::KindWrite: tx_d = {2'b00, item_i.reg_addr, item_i.wr_data};
          default:               tx_d = {lfrspi_pkg::PrefixRead | {2'b00, item_i.reg_addr},
                                         8'd0};
        endcase
        cnt_d   = 5'd0;
        half_d  = 1'b0;
        cs_d    = 1'b1;
        sck_d   = 1'b0;
        mosi_d  = 1'b0;
        phase_d = lfrspi_pkg::PH_SEND;
      end
    end else begin
      case (phase_q)
        lfrspi_pkg::PH_SEND: begin
          if (!half_q) begin
            sck_d  = 1'b1;
            mosi_d = tx_q[15];
            tx_d   = {tx_q[14:0], 1'b0};
            half_d = 1'b1;
          end else begin
            sck_d  = 1'b0;
            half_d = 1'b0;
            cnt_d  = cnt_inc;
            if (cnt_inc >= nbits) begin
              cnt_d = 5'd0;
              if (kind_q[1]) begin
                phase_d = lfrspi_pkg::PH_RECV;
              end else begin
                mosi_d  = 1'b0;
                gap_d   = gap_ticks_i;
                phase_d = lfrspi_pkg::PH_GAP;
              end
            end
          end
        end
        lfrspi_pkg::PH_RECV: begin
          if (!half_q) begin
            sck_d  = 1'b1;
            half_d = 1'b1;
          end else begin
            sck_d  = 1'b0;
            half_d = 1'b0;
            rx_d   = {rx_q[6:0], item_i.miso};
            cnt_d  = cnt_inc;
            if (cnt_inc >= lfrspi_pkg::BitsShort) begin
              cnt_d   = 5'd0;
              mosi_d  = 1'b0;
              gap_d   = gap_ticks_i;
              phase_d = lfrspi_pkg::PH_GAP;
            end
          end
        end
        lfrspi_pkg::PH_GAP: begin
          if (gap_q == 16'd0) begin
            cs_d    = 1'b0;
            sck_d   = 1'b0;
            mosi_d  = 1'b0;
            phase_d = lfrspi_pkg::PH_IDLE;
            done    = 1'b1;
          end else begin
            gap_d = gap_q - 16'd1;
          end
        end
        default: phase_d = lfrspi_pkg::PH_IDLE;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lfrspi_pkg::PH_IDLE;
      tx_q    <= 16'd0;
      cnt_q   <= 5'd0;
      half_q  <= 1'b0;
      kind_q  <= 2'd0;
      rx_q    <= 8'd0;
      gap_q   <= 16'd0;
      cs_q    <= 1'b0;
      sck_q   <= 1'b0;
      mosi_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tx_q    <= tx_d;
      cnt_q   <= cnt_d;
      half_q  <= half_d;
      kind_q  <= kind_d;
      rx_q    <= rx_d;
      gap_q   <= gap_d;
      cs_q    <= cs_d;
      sck_q   <= sck_d;
      mosi_q  <= mosi_d;
    end
  end

  // result of this request
  assign res_o.cs_level   = cs_d;
  assign res_o.sck_level  = sck_d;
  assign res_o.mosi_level = mosi_d;
  assign res_o.busy_res   = (phase_d != lfrspi_pkg::PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.read_data  = rx_d;
  assign res_o.rejected   = rej;

  // pins are all low whenever the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lfrspi_pkg::PH_IDLE) |-> (!cs_q && !sck_q && !mosi_q))
    else $error("pins active while idle");

  // chip select is high throughout a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != lfrspi_pkg::PH_IDLE) |-> cs_q)
    else $error("chip select low during a transaction");

  // a tick on the first half of a bit raises sck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.req_type == lfrspi_pkg::ReqTick && !half_q &&
     (phase_q == lfrspi_pkg::PH_SEND || phase_q == lfrspi_pkg::PH_RECV)) |=> sck_q)
    else $error("sck did not rise on first half tick");

  // the bit counter stays below the long frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < lfrspi_pkg::BitsLong)
    else $error("bit counter out of range");

endmodule
